/* rtl/tcs_pkg.sv */
// ----------------------------------------------------------------------------
// tcs_pkg
// Types and constants shared by the token credit scheduler.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int ISS_W   = $clog2(SLOTS + 1);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOKEN_CAP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_GAIN = 1'd1;

  localparam logic [14:0] TOKEN_CAP_RST   = 15'd8;
  localparam logic [8:0]  REFILL_GAIN_RST = 9'd154;
  localparam logic [8:0]  GAIN_MAX        = 9'd256;

  // commands
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_STOP   = 2'd1;
  localparam logic [1:0] CMD_CHARGE = 2'd2;
  localparam logic [1:0] CMD_REFILL = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_IDLE = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  slot;
    logic [15:0] amount;
  } tcs_in_t;

  typedef struct packed {
    logic               status;
    logic signed [15:0] slot_tokens;
    logic               eligible;
    logic [15:0]        leftover;
    logic [5:0]         last_slot;
  } tcs_out_t;

endpackage

/* rtl/token_credit_scheduler_top.sv */
// ----------------------------------------------------------------------------
// token_credit_scheduler_top
// Per-slot token credit table with start, stop, charge and round-robin refill.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_data   (tcs_in_t)
//  out      output     out_valid / out_stall  out_data  (tcs_out_t)
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Start/stop use S_EXEC, charge S_CHG, refill S_MUL and S_WALK; S_FIN and
// S_CAP give the result. The walk reads one slot per cycle from the count
// memory, one read and one write port. Input stalls until the result is in
// the output register. Reset (synchronous) clears in-use bits and pointer
// and loads config defaults; counts are not cleared. A stalled result holds
// in the output register; a new transfer is accepted meanwhile and waits
// only if its result is ready before it drains.
module token_credit_scheduler_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tcs_pkg::tcs_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tcs_pkg::tcs_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcs_pkg::CFG_DAT_W-1:0] cfg_data
);
  import tcs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CHG  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_CAP  = 3'd6;

  logic [2:0]  state, state_next;
  logic [14:0] token_cap;
  logic [8:0]  refill_gain;

  tcs_in_t             req;
  logic [SLOT_AW-1:0]  ptr;
  logic [SLOTS-1:0]    active;
  logic [15:0]         pool;
  logic                status;

  logic signed [15:0]  mem [SLOTS];
  logic signed [15:0]  rdata;
  logic [SLOT_AW-1:0]  raddr;
  logic                we;
  logic [SLOT_AW-1:0]  waddr;
  logic signed [15:0]  wdata;

  logic [SLOT_AW-1:0]  rd_idx;
  logic [ISS_W-1:0]    iss_cnt;
  logic                st_vld;
  logic [SLOT_AW-1:0]  st_idx;

  logic                slot_ok;
  logic [SLOT_AW-1:0]  req_idx;
  logic [SLOT_AW-1:0]  nxt_idx;
  logic                iss_more;
  logic [8:0]          gain_c;
  logic [24:0]         prod;
  logic signed [17:0]  sum;
  logic signed [17:0]  cap_s;
  logic signed [17:0]  diff;
  logic signed [17:0]  chg_v;
  logic                serve;
  logic                fill;
  logic [15:0]         pool_after;
  logic                walk_done;
  logic                out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  assign req_idx  = SLOT_AW'(req.slot);
  assign slot_ok  = (32'(req.slot) < SLOTS);
  assign nxt_idx  = (32'(rd_idx) == SLOTS - 1) ? '0 : rd_idx + 1'b1;
  assign iss_more = (32'(iss_cnt) < SLOTS);
  assign gain_c   = (refill_gain > GAIN_MAX) ? GAIN_MAX : refill_gain;
  assign out_free = !out_valid || !out_stall;

  // charge: signed count minus unsigned ticks
  assign chg_v = 18'(rdata) - $signed({2'b00, req.amount});

  // walk step: serve the slot whose count arrived this cycle
  assign cap_s = 18'(token_cap);
  assign sum   = 18'(rdata) + 18'(pool);
  assign diff  = sum - cap_s;
  assign serve = st_vld && active[st_idx];
  assign fill  = serve && (18'(rdata) < cap_s);

  always_comb begin
    pool_after = pool;
    if (fill) begin
      pool_after = (sum > cap_s) ? diff[15:0] : 16'd0;
    end
  end

  assign walk_done = (st_vld && pool_after == 16'd0) ||
                     (st_vld && !iss_more) || (pool == 16'd0);

  // memory port control
  always_comb begin
    raddr = req_idx;
    we    = 1'b0;
    waddr = req_idx;
    wdata = 16'(token_cap);
    unique case (state)
      S_IDLE: begin
        raddr = SLOT_AW'(in_data.slot);
      end
      S_EXEC: begin
        we = slot_ok && (req.cmd == CMD_START);
      end
      S_CHG: begin
        we    = slot_ok && active[req_idx];
        wdata = (chg_v < -18'sd32768) ? 16'sh8000 : chg_v[15:0];
      end
      S_WALK: begin
        raddr = nxt_idx;
        we    = fill;
        waddr = st_idx;
        wdata = (sum > cap_s) ? 16'(token_cap) : sum[15:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) begin
        unique case (in_data.cmd)
          CMD_CHARGE: state_next = S_CHG;
          CMD_REFILL: state_next = S_MUL;
          default:    state_next = S_EXEC;
        endcase
      end
      S_EXEC:  state_next = S_FIN;
      S_CHG:   state_next = S_FIN;
      S_MUL:   state_next = S_WALK;
      S_WALK:  if (walk_done) state_next = S_FIN;
      S_FIN:   state_next = S_CAP;
      S_CAP:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign prod = 25'(req.amount) * 25'(gain_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      token_cap   <= TOKEN_CAP_RST;
      refill_gain <= REFILL_GAIN_RST;
      active      <= '0;
      ptr         <= '0;
      out_valid   <= 1'b0;
      st_vld      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TOKEN_CAP:   token_cap   <= cfg_data[14:0];
          REG_REFILL_GAIN: refill_gain <= cfg_data[8:0];
          default: begin
          end
        endcase
      end

      if (state == S_CAP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_EXEC: if (slot_ok) begin
          active[req_idx] <= (req.cmd == CMD_START);
        end
        S_MUL: begin
          st_vld <= 1'b0;
        end
        S_WALK: begin
          st_vld <= iss_more;
          if (serve) begin
            ptr <= st_idx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        req    <= in_data;
        pool   <= 16'd0;
        status <= STATUS_OK;
      end
      S_CHG: begin
        status <= (slot_ok && !active[req_idx]) ? STATUS_IDLE : STATUS_OK;
      end
      S_MUL: begin
        pool    <= prod[23:8];
        rd_idx  <= ptr;
        iss_cnt <= '0;
      end
      S_WALK: begin
        pool <= pool_after;
        if (iss_more) begin
          rd_idx  <= nxt_idx;
          st_idx  <= nxt_idx;
          iss_cnt <= iss_cnt + 1'b1;
        end
      end
      S_CAP: if (out_free) begin
        out_data.status      <= status;
        out_data.slot_tokens <= slot_ok ? rdata : 16'sd0;
        out_data.eligible    <= slot_ok && (rdata > 16'sd0);
        out_data.leftover    <= pool;
        out_data.last_slot   <= 6'(ptr);
      end
      default: begin
      end
    endcase
  end

endmodule

/* tb/sv/token_credit_scheduler_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_credit_scheduler_top_test
// Self-checking bench for the token credit scheduler: a scripted opening
// (extremes, every command, saturation, idle-slot charge, cap and gain
// corners) followed by random command streams under three back-pressure
// mixes. Results are checked against script values or a cycle-free predictor.
// ----------------------------------------------------------------------------
module token_credit_scheduler_top_test;
  import tcs_pkg::*;

  localparam int DRAIN_CYCLES    = 80;    // longest refill walk plus margin
  localparam int LONG_HOLD       = 400;
  localparam int QUIET_LIMIT     = 4000;
  localparam int RAND_PER_PHASE  = 127;
  localparam int SCRIPT_LEN      = 28;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    tcs_in_t                item;
    bit                     known;
    tcs_out_t               res;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DAT_W-1:0]   reg_val;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  tcs_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  tcs_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  // predictor state
  logic signed [15:0] credit [SLOTS];
  bit                 in_use [SLOTS];
  logic [5:0]         rr_ptr   = '0;
  logic [14:0]        cap_reg  = TOKEN_CAP_RST;
  logic [8:0]         gain_reg = REFILL_GAIN_RST;

  bit        started [SLOTS];   // count written at least once
  tcs_out_t  awaited_reports [$];
  tcs_out_t  want;
  int        mismatch_count = 0;
  int        send_idle_pct  = 13;
  int        recv_idle_pct  = 49;
  int        hold_requests  = 0;
  int        hold_served    = 0;
  int        hold_left      = 0;
  int        quiet_cycles   = 0;

  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_ITEM, '{CMD_START, 6'd0, 16'd0}, 1'b1,
      '{STATUS_OK, 16'sd8, 1'b1, 16'd0, 6'd0}, REG_TOKEN_CAP, '0},
    '{ROW_ITEM, '{CMD_START, 6'd63, 16'd65535}, 1'b1,
      '{STATUS_OK, 16'sd8, 1'b1, 16'd0, 6'd0}, REG_TOKEN_CAP, '0},
    '{ROW_ITEM, '{CMD_CHARGE, 6'd0, 16'd3}, 1'b1,
      '{STATUS_OK, 16'sd5, 1'b1, 16'd0, 6'd0}, REG_TOKEN_CAP, '0},
    // saturates at the most negative count
    '{ROW_ITEM, '{CMD_CHARGE, 6'd63, 16'd65535}, 1'b1,
      '{STATUS_OK, 16'sh8000, 1'b0, 16'd0, 6'd0}, REG_TOKEN_CAP, '0},
    '{ROW_ITEM, '{CMD_REFILL, 6'd0, 16'd65535}, 1'b0, '0, REG_TOKEN_CAP, '0},
    '{ROW_ITEM, '{CMD_STOP, 6'd63, 16'd0}, 1'b0, '0, REG_TOKEN_CAP, '0},
    // charge on a stopped slot keeps its count
    '{ROW_ITEM, '{CMD_CHARGE, 6'd63, 16'd1}, 1'b1,
      '{STATUS_IDLE, 16'sd8, 1'b1, 16'd0, 6'd0}, REG_TOKEN_CAP, '0},
    '{ROW_ITEM, '{CMD_REFILL, 6'd0, 16'd0}, 1'b0, '0, REG_TOKEN_CAP, '0},
    '{ROW_ITEM, '{CMD_CHARGE, 6'd0, 16'd20}, 1'b0, '0, REG_TOKEN_CAP, '0},
    '{ROW_ITEM, '{CMD_REFILL, 6'd0, 16'd10}, 1'b0, '0, REG_TOKEN_CAP, '0},
    '{ROW_ITEM, '{CMD_START, 6'd63, 16'd0}, 1'b0, '0, REG_TOKEN_CAP, '0},
    '{ROW_CFG, '0, 1'b0, '0, REG_TOKEN_CAP, 15'd32767},
    '{ROW_CFG, '0, 1'b0, '0, REG_REFILL_GAIN, 15'd511},
    '{ROW_ITEM, '{CMD_START, 6'd5, 16'd0}, 1'b0, '0, REG_TOKEN_CAP, '0},
    // full slots pass the amount on, excess comes back as leftover
    '{ROW_ITEM, '{CMD_REFILL, 6'd5, 16'd65535}, 1'b0, '0, REG_TOKEN_CAP, '0},
    '{ROW_CFG, '0, 1'b0, '0, REG_TOKEN_CAP, 15'd0},
    '{ROW_CFG, '0, 1'b0, '0, REG_REFILL_GAIN, 15'd0},
    '{ROW_ITEM, '{CMD_REFILL, 6'd0, 16'd1000}, 1'b0, '0, REG_TOKEN_CAP, '0},
    '{ROW_CFG, '0, 1'b0, '0, REG_REFILL_GAIN, 15'd1},
    '{ROW_ITEM, '{CMD_REFILL, 6'd5, 16'd65535}, 1'b0, '0, REG_TOKEN_CAP, '0},
    '{ROW_ITEM, '{CMD_START, 6'd10, 16'd0}, 1'b0, '0, REG_TOKEN_CAP, '0},
    '{ROW_ITEM, '{CMD_CHARGE, 6'd10, 16'd1}, 1'b0, '0, REG_TOKEN_CAP, '0},
    '{ROW_ITEM, '{CMD_STOP, 6'd5, 16'd0}, 1'b0, '0, REG_TOKEN_CAP, '0},
    '{ROW_ITEM, '{CMD_CHARGE, 6'd5, 16'd65535}, 1'b0, '0, REG_TOKEN_CAP, '0},
    '{ROW_CFG, '0, 1'b0, '0, REG_TOKEN_CAP, 15'd1},
    '{ROW_CFG, '0, 1'b0, '0, REG_REFILL_GAIN, 15'd256},
    '{ROW_ITEM, '{CMD_REFILL, 6'd63, 16'd300}, 1'b0, '0, REG_TOKEN_CAP, '0},
    '{ROW_ITEM, '{CMD_START, 6'd42, 16'd21845}, 1'b0, '0, REG_TOKEN_CAP, '0}
  };

  token_credit_scheduler_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Updates the credit table for one command and returns what the block
  // should report for it.
  function automatic tcs_out_t apply_command(input tcs_in_t c);
    tcs_out_t    r;
    int unsigned pool;
    int unsigned gain;
    int unsigned ticks;
    int          idx;
    int          cap_i;
    int          cur;
    int          sum;
    r = '0;
    case (c.cmd)
      CMD_START: begin
        credit[c.slot] = 16'(cap_reg);
        in_use[c.slot] = 1'b1;
      end
      CMD_STOP: in_use[c.slot] = 1'b0;
      CMD_CHARGE: begin
        if (in_use[c.slot]) begin
          cur = int'(credit[c.slot]);
          ticks = 32'(c.amount);
          sum = cur - int'(ticks);
          if (sum < -32768) sum = -32768;
          credit[c.slot] = sum[15:0];
        end else begin
          r.status = STATUS_IDLE;
        end
      end
      CMD_REFILL: begin
        gain = 32'((gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg);
        ticks = 32'(c.amount);
        pool = (ticks * gain) >> 8;
        idx = int'(rr_ptr);
        cap_i = int'(cap_reg);
        // walk ends on the pointer slot itself
        for (int n = 0; n < SLOTS && pool > 0; n++) begin
          idx = (idx + 1) % SLOTS;
          if (!in_use[idx]) continue;
          rr_ptr = 6'(idx);
          cur = int'(credit[idx]);
          if (cur >= cap_i) continue;
          sum = cur + int'(pool);
          if (sum > cap_i) begin
            pool = sum - cap_i;
            credit[idx] = 16'(cap_i);
          end else begin
            credit[idx] = 16'(sum);
            pool = 0;
          end
        end
        r.leftover = 16'(pool);
      end
    endcase
    r.slot_tokens = credit[c.slot];
    r.eligible    = credit[c.slot] > 0;
    r.last_slot   = rr_ptr;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic signed [31:0] exp_v,
                                        input logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  task automatic send_command(input tcs_in_t item, input bit known, input tcs_out_t fixed);
    tcs_out_t r;
    r = apply_command(item);
    awaited_reports.push_back(known ? fixed : r);
    if (item.cmd == CMD_START) started[item.slot] = 1'b1;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // hold the input until every report is back and the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TOKEN_CAP) cap_reg = val;
    else gain_reg = val[8:0];
  endtask

  // receiver: random stalls, plus a long counted hold on request
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited_reports.size() == 0) begin
        $error("result transfer with no command outstanding");
        mismatch_count++;
      end else begin
        want = awaited_reports.pop_front();
        compare_field("status", 32'(want.status), 32'(out_data.status));
        compare_field("slot_tokens", 32'(want.slot_tokens), 32'(out_data.slot_tokens));
        compare_field("eligible", 32'(want.eligible), 32'(out_data.eligible));
        compare_field("leftover", 32'(want.leftover), 32'(out_data.leftover));
        compare_field("last_slot", 32'(want.last_slot), 32'(out_data.last_slot));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL token_credit_scheduler_top");
      $finish;
    end
  end

  initial begin
    tcs_in_t item;
    int      r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[k]) begin
      if (script[k].kind == ROW_CFG) begin
        drain();
        write_register(script[k].reg_idx, script[k].reg_val);
      end else begin
        send_command(script[k].item, script[k].known, script[k].res);
      end
    end

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 13; recv_idle_pct = 49; end
        1: begin send_idle_pct = 49; recv_idle_pct = 13; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      drain();
      write_register(REG_TOKEN_CAP,
                     ($urandom_range(3) == 0) ? 15'd32767 : 15'($urandom_range(1, 200)));
      write_register(REG_REFILL_GAIN, 15'($urandom_range(0, 511)));
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (i == 40) drain();
        if (p == 0 && i == 70) hold_requests++;
        r = int'($urandom_range(99));
        item.cmd = (r < 18) ? CMD_START : (r < 30) ? CMD_STOP :
                   (r < 65) ? CMD_CHARGE : CMD_REFILL;
        if (item.cmd == CMD_START) begin
          item.slot = 6'($urandom_range(63));
        end else begin
          // only slots whose count has been written may be addressed
          do item.slot = 6'($urandom_range(63)); while (!started[item.slot]);
        end
        r = int'($urandom_range(99));
        if (item.cmd == CMD_REFILL)
          item.amount = (r < 70) ? 16'($urandom_range(0, 511)) :
                        (r < 90) ? 16'($urandom_range(0, 8191)) :
                        16'($urandom_range(0, 65535));
        else
          item.amount = (r < 85) ? 16'($urandom_range(0, 63)) :
                        16'($urandom_range(0, 65535));
        send_command(item, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_reports.size() == 0) begin
      $display("PASS token_credit_scheduler_top");
    end else begin
      $display("FAIL token_credit_scheduler_top");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tcs_pkg.sv
rtl/token_credit_scheduler_top.sv
tb/sv/token_credit_scheduler_top_test.sv
